// ----- sv/cbdq_pkg.sv -----
package cbdq_pkg;

   // Frame and output geometry. The output side is a power of two so that the
   // sample position splits into integer and fraction by a shift.
   localparam int FRAME_WIDTH  = 640;
   localparam int FRAME_HEIGHT = 480;
   localparam int OUT_LOG2     = 7;
   localparam int OUT_SIZE     = 1 << OUT_LOG2;

   localparam int X_W = $clog2(FRAME_WIDTH);
   localparam int Y_W = $clog2(FRAME_HEIGHT);
   localparam int O_W = OUT_LOG2;
   localparam int F_W = OUT_LOG2 + 1;

   localparam int SIZE_MAX = (FRAME_WIDTH < FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
   localparam int SIZE_MIN = OUT_SIZE + 1;
   localparam int S_W      = $clog2(SIZE_MAX + 1);
   localparam int G_W      = ((X_W > Y_W) ? X_W : Y_W) + 1;
   localparam int POS_W    = O_W + 1 + S_W;

   localparam int CH_W       = 8;
   localparam int PIX_W      = 3 * CH_W;
   localparam int H_W        = CH_W + F_W + 1;
   localparam int SUM_W      = CH_W + 2 * F_W + 1;
   localparam int WEIGHT_ONE = 1 << F_W;
   localparam int ROUND_HALF = 1 << (2 * F_W - 1);
   localparam int CH_OFFSET  = 128;

   // Register file.
   localparam int ADDR_W     = 4;
   localparam int DATA_W     = 32;
   localparam int CL_W       = 10;
   localparam int CT_W       = 9;
   localparam int CS_W       = 9;
   localparam int CL_RESET   = 120;
   localparam int CT_RESET   = 40;
   localparam int CS_RESET   = 400;

   typedef enum logic [1:0] {
      REG_CROP_LEFT = 2'd0,
      REG_CROP_TOP  = 2'd1,
      REG_CROP_SIZE = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [CL_W-1:0] crop_left;
      logic [CT_W-1:0] crop_top;
      logic [CS_W-1:0] crop_size;
   } cfg_type;

   // Next sample point: the source pixel that completes it, and its weights.
   typedef struct packed {
      logic [X_W-1:0] x1;
      logic [Y_W-1:0] y1;
      logic           xs;
      logic           ys;
      logic [F_W-1:0] fx;
      logic [F_W-1:0] fy;
   } target_type;

   typedef struct packed {
      logic             valid;
      logic [PIX_W-1:0] p00;
      logic [PIX_W-1:0] p10;
      logic [PIX_W-1:0] p01;
      logic [PIX_W-1:0] p11;
      logic [F_W-1:0]   fx;
      logic [F_W-1:0]   fy;
      logic             frame_end;
   } blend_in_type;

   typedef struct packed {
      logic            valid;
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            frame_end;
   } blend_out_type;

endpackage

// ----- sv/cbdq_ram.sv -----
module cbdq_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 640
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Read returns the old contents when the same entry is written in that cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- sv/cbdq_csr.sv -----
module cbdq_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [cbdq_pkg::ADDR_W-1:0] paddr,
   input  logic [cbdq_pkg::DATA_W-1:0] pwdata,
   output logic [cbdq_pkg::DATA_W-1:0] prdata,
   output logic                        pready,
   output cbdq_pkg::cfg_type           cfg,
   output logic                        cfg_wr
);
   import cbdq_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   assign index  = reg_index_type'(paddr[ADDR_W-1:2]);
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_wr) begin
         case (index)
            REG_CROP_LEFT: cfg_in.crop_left = pwdata[CL_W-1:0];
            REG_CROP_TOP:  cfg_in.crop_top  = pwdata[CT_W-1:0];
            REG_CROP_SIZE: cfg_in.crop_size = pwdata[CS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_CROP_LEFT: prdata = DATA_W'(cfg_ff.crop_left);
         REG_CROP_TOP:  prdata = DATA_W'(cfg_ff.crop_top);
         REG_CROP_SIZE: prdata = DATA_W'(cfg_ff.crop_size);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crop_left <= CL_W'(CL_RESET);
         cfg_ff.crop_top  <= CT_W'(CT_RESET);
         cfg_ff.crop_size <= CS_W'(CS_RESET);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- sv/cbdq_geom.sv -----
module cbdq_geom (
   input  logic                     clock,
   input  cbdq_pkg::cfg_type        cfg,
   input  logic [cbdq_pkg::O_W-1:0] out_col,
   input  logic [cbdq_pkg::O_W-1:0] out_row,
   output cbdq_pkg::target_type     target
);
   import cbdq_pkg::*;

   logic [S_W-1:0]   size_eff;
   logic [G_W-1:0]   size_g;
   logic [G_W-1:0]   left_lim;
   logic [G_W-1:0]   top_lim;
   logic [G_W-1:0]   left_eff;
   logic [G_W-1:0]   top_eff;
   logic [POS_W-1:0] col_pos;
   logic [POS_W-1:0] row_pos;

   logic [S_W-1:0]   size_ff;
   logic [G_W-1:0]   left_ff;
   logic [G_W-1:0]   top_ff;
   logic [POS_W-1:0] col_pos_ff;
   logic [POS_W-1:0] row_pos_ff;

   logic [G_W-1:0]   col_x0;
   logic [G_W-1:0]   col_end;
   logic [G_W-1:0]   row_y0;
   logic [G_W-1:0]   row_end;
   logic             col_same;
   logic             row_same;
   target_type       target_in;
   target_type       target_ff;

   // First stage: saturate the crop square and form the numerators (2d+1)S-N.
   always_comb begin
      if (G_W'(cfg.crop_size) > G_W'(SIZE_MAX)) begin
         size_eff = S_W'(SIZE_MAX);
      end else if (G_W'(cfg.crop_size) < G_W'(SIZE_MIN)) begin
         size_eff = S_W'(SIZE_MIN);
      end else begin
         size_eff = S_W'(cfg.crop_size);
      end
      size_g   = G_W'(size_eff);
      left_lim = G_W'(FRAME_WIDTH) - size_g;
      top_lim  = G_W'(FRAME_HEIGHT) - size_g;
      left_eff = (G_W'(cfg.crop_left) > left_lim) ? left_lim : G_W'(cfg.crop_left);
      top_eff  = (G_W'(cfg.crop_top) > top_lim) ? top_lim : G_W'(cfg.crop_top);
      col_pos  = POS_W'({out_col, 1'b1}) * POS_W'(size_eff) - POS_W'(OUT_SIZE);
      row_pos  = POS_W'({out_row, 1'b1}) * POS_W'(size_eff) - POS_W'(OUT_SIZE);
   end

   always_ff @(posedge clock) begin
      size_ff    <= size_eff;
      left_ff    <= left_eff;
      top_ff     <= top_eff;
      col_pos_ff <= col_pos;
      row_pos_ff <= row_pos;
   end

   // Second stage: integer sample point, far neighbor clamped to the crop edge.
   always_comb begin
      col_x0   = left_ff + G_W'(col_pos_ff >> F_W);
      col_end  = left_ff + G_W'(size_ff) - G_W'(1);
      row_y0   = top_ff + G_W'(row_pos_ff >> F_W);
      row_end  = top_ff + G_W'(size_ff) - G_W'(1);
      col_same = (col_x0 >= col_end);
      row_same = (row_y0 >= row_end);
      target_in.x1 = X_W'(col_same ? col_end : col_x0 + G_W'(1));
      target_in.y1 = Y_W'(row_same ? row_end : row_y0 + G_W'(1));
      target_in.xs = col_same;
      target_in.ys = row_same;
      target_in.fx = col_pos_ff[F_W-1:0];
      target_in.fy = row_pos_ff[F_W-1:0];
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
   end

   assign target = target_ff;

endmodule

// ----- sv/cbdq_blend.sv -----
module cbdq_blend (
   input  logic                    clock,
   input  logic                    reset,
   input  cbdq_pkg::blend_in_type  bl_in,
   output cbdq_pkg::blend_out_type bl_out,
   output logic                    busy
);
   import cbdq_pkg::*;

   logic [H_W-1:0]   h_top [3];
   logic [H_W-1:0]   h_bot [3];
   logic [H_W-1:0]   wx0;
   logic [H_W-1:0]   wx1;
   logic [H_W-1:0]   h_top_ff [3];
   logic [H_W-1:0]   h_bot_ff [3];
   logic [F_W-1:0]   fy1_ff;
   logic             fe1_ff;
   logic             v1_ff;

   logic [SUM_W-1:0] wy0;
   logic [SUM_W-1:0] wy1;
   logic [SUM_W-1:0] sum [3];
   logic [SUM_W-1:0] sum_ff [3];
   logic             fe2_ff;
   logic             v2_ff;

   logic [CH_W-1:0]  q [3];

   // Horizontal pass: blend the row above and the current row per channel.
   always_comb begin
      wx1 = H_W'(bl_in.fx);
      wx0 = H_W'(WEIGHT_ONE) - wx1;
      for (int c = 0; c < 3; c++) begin
         h_top[c] = H_W'(bl_in.p00[PIX_W-1-CH_W*c -: CH_W]) * wx0
                  + H_W'(bl_in.p10[PIX_W-1-CH_W*c -: CH_W]) * wx1;
         h_bot[c] = H_W'(bl_in.p01[PIX_W-1-CH_W*c -: CH_W]) * wx0
                  + H_W'(bl_in.p11[PIX_W-1-CH_W*c -: CH_W]) * wx1;
      end
   end

   always_ff @(posedge clock) begin
      h_top_ff <= h_top;
      h_bot_ff <= h_bot;
      fy1_ff   <= bl_in.fy;
      fe1_ff   <= bl_in.frame_end;
   end

   // Vertical pass.
   always_comb begin
      wy1 = SUM_W'(fy1_ff);
      wy0 = SUM_W'(WEIGHT_ONE) - wy1;
      for (int c = 0; c < 3; c++) begin
         sum[c] = SUM_W'(h_top_ff[c]) * wy0 + SUM_W'(h_bot_ff[c]) * wy1;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum;
      fe2_ff <= fe1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= bl_in.valid;
         v2_ff <= v1_ff;
      end
   end

   // Round half up and remove the offset. The weights sum to one, so the
   // rounded value never leaves the byte range and no clamp is needed.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         q[c] = CH_W'((sum_ff[c] + SUM_W'(ROUND_HALF)) >> (2 * F_W)) - CH_W'(CH_OFFSET);
      end
   end

   assign bl_out.valid     = v2_ff;
   assign bl_out.red       = q[0];
   assign bl_out.green     = q[1];
   assign bl_out.blue      = q[2];
   assign bl_out.frame_end = fe2_ff;
   assign busy             = v1_ff || v2_ff;

endmodule

// ----- sv/crop_bilinear_downscale_quantize_core.sv -----
// Channel   | Dir | Handshake              | Item or contents
// --------- | --- | ---------------------- | -----------------------------------------------
// request   | in  | req_valid / req_ready  | one RGB888 source pixel in raster order
// response  | out | rsp_valid / rsp_ready  | one output pixel, three signed bytes
// config    | in  | psel, penable, pwrite  | crop_left at 0x0, crop_top at 0x4, crop_size at 0x8
//
// A source pixel that completes no output sample waits only for the settle counter, never for the result path.
// After a pixel that completes a sample, and after a frame start, a frame wrap or a
// register write, req_ready stays low while the two-stage target unit recomputes the
// next sample point from the output counters.
// A pixel that would complete a sample waits while the previous result is still in the
// three-stage blend pipeline or the response register, so only one output pixel is in
// flight at a time. Reset clears the counters; the line store needs no clearing pass.
// A stalled response holds its item while pixels that complete no sample keep flowing.
module crop_bilinear_downscale_quantize_core (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [cbdq_pkg::CH_W-1:0]    req_red,
   input  logic [cbdq_pkg::CH_W-1:0]    req_green,
   input  logic [cbdq_pkg::CH_W-1:0]    req_blue,
   input  logic                         req_frame_start,

   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [cbdq_pkg::CH_W-1:0] rsp_out_red,
   output logic signed [cbdq_pkg::CH_W-1:0] rsp_out_green,
   output logic signed [cbdq_pkg::CH_W-1:0] rsp_out_blue,
   output logic                         rsp_frame_end,

   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [cbdq_pkg::ADDR_W-1:0]  paddr,
   input  logic [cbdq_pkg::DATA_W-1:0]  pwdata,
   output logic [cbdq_pkg::DATA_W-1:0]  prdata,
   output logic                         pready
);
   import cbdq_pkg::*;

   localparam logic [1:0] SETTLE_CYCLES = 2'd2;

   cfg_type          cfg;
   logic             cfg_wr;
   target_type       target;

   // Raster position and output counters.
   logic [X_W-1:0]   x_ff, x_in, x_cur;
   logic [Y_W-1:0]   y_ff, y_in, y_cur;
   logic [O_W-1:0]   oc_ff, oc_in, oc_base;
   logic [O_W-1:0]   or_ff, or_in, or_base;
   logic             done_ff, done_in, done_cur;
   logic [1:0]       busy_ff, busy_in;

   logic             req_fire;
   logic             hit;
   logic             last_col;
   logic             last_row;
   logic             wrap;
   logic             last_sample;
   logic             outstanding;

   // First pipeline stage: the accepted pixel while its line store read completes.
   logic             s1_valid_ff;
   logic             s1_emit_ff;
   logic [PIX_W-1:0] s1_cur_ff;
   logic [X_W-1:0]   s1_x_ff;
   logic             s1_fwd_ff;
   logic [PIX_W-1:0] s1_fwd_data_ff;
   logic             s1_xs_ff;
   logic             s1_ys_ff;
   logic [F_W-1:0]   s1_fx_ff;
   logic [F_W-1:0]   s1_fy_ff;
   logic             s1_fe_ff;

   logic [PIX_W-1:0] left_ff;
   logic [PIX_W-1:0] above_left_ff;
   logic [PIX_W-1:0] ram_rdata;
   logic [PIX_W-1:0] above;

   blend_in_type     bl_in;
   blend_out_type    bl_out;
   logic             bl_busy;

   logic             rsp_valid_ff;
   logic [CH_W-1:0]  rsp_red_ff;
   logic [CH_W-1:0]  rsp_green_ff;
   logic [CH_W-1:0]  rsp_blue_ff;
   logic             rsp_fe_ff;

   cbdq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg),
      .cfg_wr  (cfg_wr)
   );

   // The target unit always works from the counters and registers; the settle
   // counter keeps pixels out until its result matches them.
   cbdq_geom u_geom (
      .clock   (clock),
      .out_col (oc_ff),
      .out_row (or_ff),
      .cfg     (cfg),
      .target  (target)
   );

   // A frame start places the pixel at the origin and reopens the frame. The
   // origin pixel can never complete a sample, since the far neighbor lies at
   // least one column to the right.
   always_comb begin
      x_cur    = req_frame_start ? '0 : x_ff;
      y_cur    = req_frame_start ? '0 : y_ff;
      oc_base  = req_frame_start ? '0 : oc_ff;
      or_base  = req_frame_start ? '0 : or_ff;
      done_cur = req_frame_start ? 1'b0 : done_ff;
      hit      = !done_cur && (x_cur == target.x1) && (y_cur == target.y1);
      last_col = (x_cur == X_W'(FRAME_WIDTH - 1));
      last_row = (y_cur == Y_W'(FRAME_HEIGHT - 1));
      wrap     = last_col && last_row;
      last_sample = (oc_base == O_W'(OUT_SIZE - 1)) && (or_base == O_W'(OUT_SIZE - 1));
   end

   // Only one result is in flight at a time, so the response register never
   // overflows and never has to push back into the blend pipeline.
   assign outstanding = (s1_valid_ff && s1_emit_ff) || bl_busy || rsp_valid_ff;
   assign req_ready   = (busy_ff == 2'd0) && !(hit && outstanding);
   assign req_fire    = req_valid && req_ready;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      oc_in   = oc_ff;
      or_in   = or_ff;
      done_in = done_ff;
      if (req_fire) begin
         x_in    = last_col ? '0 : x_cur + X_W'(1);
         y_in    = last_col ? (last_row ? '0 : y_cur + Y_W'(1)) : y_cur;
         oc_in   = oc_base;
         or_in   = or_base;
         done_in = done_cur;
         if (hit) begin
            if (oc_base == O_W'(OUT_SIZE - 1)) begin
               oc_in = '0;
               if (or_base == O_W'(OUT_SIZE - 1)) begin
                  or_in   = '0;
                  done_in = 1'b1;
               end else begin
                  or_in = or_base + O_W'(1);
               end
            end else begin
               oc_in = oc_base + O_W'(1);
            end
         end
         if (wrap) begin
            oc_in   = '0;
            or_in   = '0;
            done_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (cfg_wr || (req_fire && (hit || req_frame_start || wrap))) begin
         busy_in = SETTLE_CYCLES;
      end else if (busy_ff != 2'd0) begin
         busy_in = busy_ff - 2'd1;
      end else begin
         busy_in = busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff    <= '0;
         y_ff    <= '0;
         oc_ff   <= '0;
         or_ff   <= '0;
         done_ff <= 1'b0;
         busy_ff <= SETTLE_CYCLES;
      end else begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         oc_ff   <= oc_in;
         or_ff   <= or_in;
         done_ff <= done_in;
         busy_ff <= busy_in;
      end
   end

   // The line store is read when the pixel is accepted and written back with
   // that pixel in the following cycle. Two pixels in a row at the same column (a
   // frame start right after a pixel in column zero) would read before the write
   // lands, so the pending pixel is forwarded.
   cbdq_ram #(
      .WIDTH (PIX_W),
      .DEPTH (FRAME_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_x_ff),
      .wr_data (s1_cur_ff),
      .rd_en   (req_fire),
      .rd_addr (x_cur),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_emit_ff     <= hit;
         s1_cur_ff      <= {req_red, req_green, req_blue};
         s1_x_ff        <= x_cur;
         s1_fwd_ff      <= s1_valid_ff && (s1_x_ff == x_cur);
         s1_fwd_data_ff <= s1_cur_ff;
         s1_xs_ff       <= target.xs;
         s1_ys_ff       <= target.ys;
         s1_fx_ff       <= target.fx;
         s1_fy_ff       <= target.fy;
         s1_fe_ff       <= last_sample;
      end
   end

   assign above = s1_fwd_ff ? s1_fwd_data_ff : ram_rdata;

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         left_ff       <= s1_cur_ff;
         above_left_ff <= above;
      end
   end

   // Neighbor selection. When the far neighbor was clamped onto the near one,
   // the near one is the current pixel, the one above it or the one to its left.
   always_comb begin
      bl_in.valid     = s1_valid_ff && s1_emit_ff;
      bl_in.p11       = s1_cur_ff;
      bl_in.p10       = s1_ys_ff ? s1_cur_ff : above;
      bl_in.p01       = s1_xs_ff ? s1_cur_ff : left_ff;
      if (s1_xs_ff) begin
         bl_in.p00 = s1_ys_ff ? s1_cur_ff : above;
      end else begin
         bl_in.p00 = s1_ys_ff ? left_ff : above_left_ff;
      end
      bl_in.fx        = s1_fx_ff;
      bl_in.fy        = s1_fy_ff;
      bl_in.frame_end = s1_fe_ff;
   end

   cbdq_blend u_blend (
      .clock  (clock),
      .reset  (reset),
      .bl_in  (bl_in),
      .bl_out (bl_out),
      .busy   (bl_busy)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (bl_out.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (bl_out.valid) begin
         rsp_red_ff   <= bl_out.red;
         rsp_green_ff <= bl_out.green;
         rsp_blue_ff  <= bl_out.blue;
         rsp_fe_ff    <= bl_out.frame_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_red_ff;
   assign rsp_out_green = rsp_green_ff;
   assign rsp_out_blue  = rsp_blue_ff;
   assign rsp_frame_end = rsp_fe_ff;

   // A pixel that completes a sample closes the input until the new target settles.
   a_settle_after_hit : assert property (@(posedge clock) disable iff (reset)
      (req_fire && hit) |=> !req_ready)
      else $error("pixel accepted before the next target settled");

   // A result from the blend pipeline never lands on an occupied response register.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      bl_out.valid |-> !rsp_valid_ff)
      else $error("result arrived while the response register was full");

   // The frame closes only on the pixel that completes the last sample.
   a_done_on_last : assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(req_fire && hit && last_sample))
      else $error("frame closed without its last sample");

endmodule
